@@ design/first_repeat_run_length_core_macros.svh @@
// assertion macros for the first repeat run length checker
// clocked, reset-qualified immediate and next-cycle implications
`ifndef FIRST_REPEAT_RUN_LENGTH_CORE_MACROS_SVH
`define FIRST_REPEAT_RUN_LENGTH_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FRRL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FRRL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/frrl_pkg.sv @@
// shared constants, types and state codes for the first repeat run length core
// no dependencies
package frrl_pkg;

  localparam int unsigned RANGE_MAX = 1024;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RANGE_W   = 11;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned ADDR_W    = $clog2(RANGE_MAX);
  localparam int unsigned STEP_W    = $clog2(WORD_W);
  localparam int unsigned EPOCH_W   = 8;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(365);
  localparam logic [RANGE_W-1:0] RANGE_ONE   = RANGE_W'(1);
  localparam logic [RANGE_W-1:0] RANGE_TOP   = RANGE_W'(RANGE_MAX);

  localparam logic [CNT_W-1:0] DRAWS_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] DRAWS_MAX = CNT_W'(RANGE_MAX + 1);

  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic [WORD_W-1:0] WORD_TOP = '1;

  typedef struct packed {
    logic [WORD_W-1:0]  quot_word;
    logic [WORD_W-1:0]  quot_top;
    logic [RANGE_W-1:0] rem_word;
    logic [RANGE_W-1:0] rem_top;
  } div_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_LOOK  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_e;

endpackage

@@ design/frrl_if.sv @@
// valid/ready channels of the first repeat run length core
// depends on frrl_pkg
interface frrl_in_if import frrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface frrl_out_if import frrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] draws_until_repeat;

  modport source (output valid, output draws_until_repeat, input ready);
  modport sink   (input valid, input draws_until_repeat, output ready);
endinterface

@@ design/first_repeat_run_length_core.sv @@
// first repeat run length core: counts draws until a reduced value repeats
// top level with sequencer, run count and epoch-marked seen table
// depends on frrl_pkg, frrl_if, frrl_div, frrl_ram
//
// usage
// - in_i takes one raw 32-bit random word per handshake; out_i delivers one
//   draws_until_repeat word each time a reduced value repeats within a run
// - range_size_we_i with range_size_i writes the range; write only when idle
// - from acceptance until ready returns, each word passes the divide state
//   (32 bit steps and a done step), one table read and one table check; a
//   word in the biased top band skips the check
// - words in the biased top band and first-seen values give no output word
// - the seen table stores a run epoch per value; after reset and after every
//   255th run a clearing pass over all 1024 entries runs with ready low
// - the output word sits in a register; a stalled receiver holds it, and the
//   core keeps taking words until a second result finds the register full,
//   where it waits in the check step
module first_repeat_run_length_core import frrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               range_size_we_i,
  input  logic [RANGE_W-1:0] range_size_i,
  frrl_in_if.sink            in_i,
  frrl_out_if.source         out_i
);

  state_e             state_q, state_d;
  logic [RANGE_W-1:0] range_q, range_eff;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]   out_data_q, out_data_d;
  logic               accept, reject, seen;
  div_stat_t          div_stat;
  div_res_t           div_res;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [EPOCH_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    priority if (range_q == '0) begin
      range_eff = RANGE_ONE;
    end else if (range_q > RANGE_TOP) begin
      range_eff = RANGE_TOP;
    end else begin
      range_eff = range_q;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  frrl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .word_i  (in_i.random_word),
    .range_i (range_eff),
    .stat_o  (div_stat),
    .res_o   (div_res)
  );

  frrl_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (RANGE_MAX)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = div_res.rem_word[ADDR_W-1:0];
  assign reject    = (div_res.rem_top != (range_eff - RANGE_ONE))
                  && (div_res.quot_word == div_res.quot_top);
  assign seen      = (ram_rdata == epoch_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = ram_raddr;
    ram_wdata   = epoch_q;

    if (out_valid_q && out_i.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = EPOCH_NONE;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = reject ? ST_IDLE : ST_CHECK;
      end
      ST_CHECK: begin
        if (!seen) begin
          ram_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_i.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = count_q + CNT_W'(1);
          count_d     = '0;
          if (epoch_q == EPOCH_LAST) begin
            epoch_d = EPOCH_FIRST;
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + EPOCH_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      range_q     <= RANGE_RESET;
      count_q     <= '0;
      epoch_q     <= EPOCH_FIRST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (range_size_we_i) begin
        range_q <= range_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_i.valid              = out_valid_q;
  assign out_i.draws_until_repeat = out_data_q;

endmodule

@@ design/frrl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module frrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/frrl_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// divides the word and the all-ones limit by the same range; depends on frrl_pkg
module frrl_div import frrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WORD_W-1:0]  word_i,
  input  logic [RANGE_W-1:0] range_i,
  output div_stat_t          stat_o,
  output div_res_t           res_o
);

  logic [WORD_W-1:0]  wq_q, wq_d, tq_q, tq_d;
  logic [RANGE_W-1:0] wr_q, wr_d, tr_q, tr_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [RANGE_W:0]   w_sh, t_sh, w_sub, t_sub;
  logic               w_ge, t_ge;

  // one compare-subtract per lane
  always_comb begin
    w_sh  = {wr_q, wq_q[WORD_W-1]};
    t_sh  = {tr_q, tq_q[WORD_W-1]};
    w_ge  = (w_sh >= {1'b0, range_i});
    t_ge  = (t_sh >= {1'b0, range_i});
    w_sub = w_ge ? (w_sh - {1'b0, range_i}) : w_sh;
    t_sub = t_ge ? (t_sh - {1'b0, range_i}) : t_sh;
  end

  always_comb begin
    wq_d   = wq_q;
    tq_d   = tq_q;
    wr_d   = wr_q;
    tr_d   = tr_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      wq_d   = word_i;
      tq_d   = WORD_TOP;
      wr_d   = '0;
      tr_d   = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      wq_d   = {wq_q[WORD_W-2:0], w_ge};
      tq_d   = {tq_q[WORD_W-2:0], t_ge};
      wr_d   = w_sub[RANGE_W-1:0];
      tr_d   = t_sub[RANGE_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wq_q <= wq_d;
    tq_q <= tq_d;
    wr_q <= wr_d;
    tr_q <= tr_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign res_o  = '{quot_word: wq_q, quot_top: tq_q, rem_word: wr_q, rem_top: tr_q};

endmodule

@@ design/frrl_checker.sv @@
// port-level checker for the first repeat run length core, bound to the top
// depends on frrl_pkg and first_repeat_run_length_core_macros.svh
`include "first_repeat_run_length_core_macros.svh"

module frrl_checker import frrl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CNT_W-1:0] out_data_i
);

  `FRRL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_data_i), "output word dropped while stalled")

  `FRRL_ASSERT_IMP(a_out_bounds, clk_i, rst_ni, out_valid_i,
                   (out_data_i >= DRAWS_MIN) && (out_data_i <= DRAWS_MAX),
                   "draw count out of bounds")

  `FRRL_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i,
                   !in_ready_i, "ready while a word is in the divider")

  `FRRL_ASSERT_IMP(a_no_early_result, clk_i, rst_ni, $rose(out_valid_i),
                   !$past(in_valid_i && in_ready_i), "result right after acceptance")

endmodule

bind first_repeat_run_length_core frrl_checker u_frrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_i.valid),
  .out_ready_i (out_i.ready),
  .out_data_i  (out_i.draws_until_repeat)
);
